>>> rtl/ssdbm_pkg.sv
// shared types and constants of the ssd block matching disparity unit
package ssdbm_pkg;

  localparam int PIX_W      = 8;
  localparam int SQ_W       = 16;
  localparam int COST_W     = 24;
  localparam int OUT_DISP_W = 6;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 9;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 8'd3;

  // register reset values
  localparam logic [6:0] RST_MAX_DISP = 7'd16;
  localparam logic [2:0] RST_RADIUS   = 3'd2;
  localparam logic [8:0] RST_WIDTH    = 9'd256;
  localparam logic [8:0] RST_HEIGHT   = 9'd256;

  // item kinds
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // tag that travels with each pixel pair read
  typedef struct packed {
    logic vld;
    logic last_pix;
    logic last_all;
  } tag_t;

endpackage

>>> rtl/ssdbm_ram.sv
// generic single write port, single read port ram with registered read
module ssdbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ssdbm_seq.sv
// window and disparity address sequencer, one pixel pair read per cycle
module ssdbm_seq
  import ssdbm_pkg::*;
#(
  parameter int MAX_WIDTH      = 256,
  parameter int MAX_HEIGHT     = 256,
  parameter int MAX_DISP_LIMIT = 64
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            start,
  input  logic [7:0]                                      col,
  input  logic [7:0]                                      row,
  input  logic [2:0]                                      radius,
  input  logic [$clog2(MAX_WIDTH)-1:0]                    w1,
  input  logic [$clog2(MAX_HEIGHT)-1:0]                   h1,
  input  logic [$clog2(MAX_DISP_LIMIT)-1:0]               nd1,
  output logic                                            empty,
  output logic                                            run,
  output tag_t                                            tag,
  output logic [$clog2(MAX_DISP_LIMIT)-1:0]               d,
  output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] laddr,
  output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] raddr
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int DW = $clog2(MAX_DISP_LIMIT);
  localparam int MW = (CW > RW) ? CW : RW;
  localparam int AW = ((MW > 8) ? MW : 8) + 2;

  logic [AW-1:0] col_x, row_x, r_x, w1_x, h1_x;
  logic [AW-1:0] j0_x, j1_x, i0_x, i1_x, sum_x;
  logic [CW-1:0] sc;
  logic          last_pix, last_all;

  logic          run_r;
  logic [CW-1:0] jj_r, j0_r, j1_r;
  logic [RW-1:0] ii_r, i0_r, i1_r;
  logic [DW-1:0] d_r;

  always_comb begin
    col_x = AW'(col);
    row_x = AW'(row);
    r_x   = AW'(radius);
    w1_x  = AW'(w1);
    h1_x  = AW'(h1);
    j0_x  = (col_x >= r_x) ? col_x - r_x : '0;
    j1_x  = (col_x + r_x > w1_x) ? w1_x : col_x + r_x;
    i0_x  = (row_x >= r_x) ? row_x - r_x : '0;
    i1_x  = (row_x + r_x > h1_x) ? h1_x : row_x + r_x;
    empty = (j0_x > w1_x) || (i0_x > h1_x);
  end

  // shifted first-image column, held at the right border
  always_comb begin
    sum_x = AW'(jj_r) + AW'(d_r);
    sc    = (sum_x > w1_x) ? w1 : sum_x[CW-1:0];
  end

  assign last_pix = (jj_r == j1_r) && (ii_r == i1_r);
  assign last_all = last_pix && (d_r == nd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      jj_r  <= '0;
      ii_r  <= '0;
      d_r   <= '0;
      j0_r  <= '0;
      j1_r  <= '0;
      i0_r  <= '0;
      i1_r  <= '0;
    end else if (start && !empty) begin
      run_r <= 1'b1;
      jj_r  <= j0_x[CW-1:0];
      ii_r  <= i0_x[RW-1:0];
      d_r   <= '0;
      j0_r  <= j0_x[CW-1:0];
      j1_r  <= j1_x[CW-1:0];
      i0_r  <= i0_x[RW-1:0];
      i1_r  <= i1_x[RW-1:0];
    end else if (run_r) begin
      if (jj_r == j1_r) begin
        jj_r <= j0_r;
        if (ii_r == i1_r) begin
          ii_r <= i0_r;
          if (d_r == nd1) begin
            run_r <= 1'b0;
          end else begin
            d_r <= d_r + 1'b1;
          end
        end else begin
          ii_r <= ii_r + 1'b1;
        end
      end else begin
        jj_r <= jj_r + 1'b1;
      end
    end
  end

  assign run          = run_r;
  assign tag.vld      = run_r;
  assign tag.last_pix = last_pix;
  assign tag.last_all = last_all;
  assign d            = d_r;
  assign laddr        = {ii_r, sc};
  assign raddr        = {ii_r, jj_r};

endmodule

>>> rtl/ssdbm_acc.sv
// difference, square, window accumulate and winner-take-all select
module ssdbm_acc
  import ssdbm_pkg::*;
#(
  parameter int MAX_DISP_LIMIT = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tag_t                              tag_in,
  input  logic [$clog2(MAX_DISP_LIMIT)-1:0] d_in,
  input  logic [PIX_W-1:0]                  lpix,
  input  logic [PIX_W-1:0]                  rpix,
  output logic                              done,
  output logic                              busy,
  output logic [COST_W-1:0]                 best_cost,
  output logic [$clog2(MAX_DISP_LIMIT)-1:0] best_d
);

  localparam int DW = $clog2(MAX_DISP_LIMIT);

  tag_t              p1_tag_r, p2_tag_r, p3_tag_r;
  logic [DW-1:0]     p1_d_r, p2_d_r, p3_d_r;
  logic [PIX_W-1:0]  p2_abs_r;
  logic [SQ_W-1:0]   p3_sq_r;
  logic [COST_W-1:0] acc_r, best_r;
  logic [DW-1:0]     best_d_r;
  logic [PIX_W-1:0]  abs_diff;
  logic [COST_W-1:0] cost;

  assign abs_diff = (lpix >= rpix) ? lpix - rpix : rpix - lpix;
  assign cost     = acc_r + COST_W'(p3_sq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_tag_r <= '0;
      p2_tag_r <= '0;
      p3_tag_r <= '0;
      acc_r    <= '0;
    end else begin
      p1_tag_r <= tag_in;
      p2_tag_r <= p1_tag_r;
      p3_tag_r <= p2_tag_r;
      if (p3_tag_r.vld) begin
        acc_r <= p3_tag_r.last_pix ? '0 : cost;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_d_r   <= d_in;
    p2_d_r   <= p1_d_r;
    p2_abs_r <= abs_diff;
    p3_d_r   <= p2_d_r;
    p3_sq_r  <= p2_abs_r * p2_abs_r;
    // first disparity seeds the best, later ones win only when strictly lower
    if (p3_tag_r.vld && p3_tag_r.last_pix && ((p3_d_r == '0) || (cost < best_r))) begin
      best_r   <= cost;
      best_d_r <= p3_d_r;
    end
  end

  assign done      = p3_tag_r.vld && p3_tag_r.last_all;
  assign busy      = p1_tag_r.vld || p2_tag_r.vld || p3_tag_r.vld;
  assign best_cost = best_r;
  assign best_d    = best_d_r;

endmodule

>>> rtl/ssd_block_match_disparity_unit.sv
// top level of the ssd block matching stereo disparity unit
//
// Store items (tuser 0) write one left and one right 8-bit pixel at (col,row);
// stores outside MAX_WIDTH by MAX_HEIGHT are dropped.
// Query items (tuser 1) return the disparity with the lowest sum of squared
// differences over a window of radius window_radius clipped to the image,
// the lowest disparity winning a tie. Each pixel image sits in its own ram
// with one read port, so a query reads one pixel pair per cycle, nd *
// (window columns) * (window rows) pairs in all, where nd is the clamped
// max_disparity: up to 64 * 15 * 15 = 14400 pair reads with the largest
// settings. A query whose window misses the image returns disparity 0,
// cost 0. One item is worked on at a time; a finished result sits in the
// output register while the next item is taken.
// Configuration writes are taken at any time but must only be issued while
// the unit is idle. Pixels must be written before a query reads them; the
// rams are not cleared after reset.
module ssd_block_match_disparity_unit
  import ssdbm_pkg::*;
#(
  parameter int MAX_WIDTH      = 256,
  parameter int MAX_HEIGHT     = 256,
  parameter int MAX_DISP_LIMIT = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input item channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // col, row, left_pixel, right_pixel
  input  logic                  in_tuser,   // op
  // result item channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // disparity, best_cost, zero pad
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int DW = $clog2(MAX_DISP_LIMIT);
  localparam int AB = CW + RW;
  localparam int OUT_PAD = OUT_DATA_W - OUT_DISP_W - COST_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // configuration registers
  logic [6:0] max_disp_r;
  logic [2:0] radius_r;
  logic [8:0] width_r;
  logic [8:0] height_r;

  logic [1:0]  state_r;
  logic        empty_r;
  logic        out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  // input fields
  logic       op;
  logic [7:0] col, row, left_pixel, right_pixel;

  logic          in_acc, store_go, query_go, store_in_range;
  logic [CW-1:0] w1;
  logic [RW-1:0] h1;
  logic [DW-1:0] nd1;

  logic          seq_empty, seq_run;
  tag_t          seq_tag;
  logic [DW-1:0] seq_d;
  logic [AB-1:0] laddr, raddr, waddr;
  logic [PIX_W-1:0] lpix, rpix;

  logic              acc_done, acc_busy;
  logic [COST_W-1:0] best_cost;
  logic [DW-1:0]     best_d;
  logic              out_free;

  assign op          = in_tuser;
  assign col         = in_tdata[7:0];
  assign row         = in_tdata[15:8];
  assign left_pixel  = in_tdata[23:16];
  assign right_pixel = in_tdata[31:24];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign store_in_range = (int'(col) < MAX_WIDTH) && (int'(row) < MAX_HEIGHT);
  assign store_go  = in_acc && (op == OP_STORE) && store_in_range;
  assign query_go  = in_acc && (op == OP_QUERY);
  assign waddr     = {RW'(row), CW'(col)};

  // clamped limits, zero counts act as one
  always_comb begin
    if (width_r == 9'd0) begin
      w1 = '0;
    end else if (int'(width_r) > MAX_WIDTH) begin
      w1 = CW'(MAX_WIDTH - 1);
    end else begin
      w1 = CW'(width_r - 9'd1);
    end
    if (height_r == 9'd0) begin
      h1 = '0;
    end else if (int'(height_r) > MAX_HEIGHT) begin
      h1 = RW'(MAX_HEIGHT - 1);
    end else begin
      h1 = RW'(height_r - 9'd1);
    end
    if (max_disp_r == 7'd0) begin
      nd1 = '0;
    end else if (int'(max_disp_r) > MAX_DISP_LIMIT) begin
      nd1 = DW'(MAX_DISP_LIMIT - 1);
    end else begin
      nd1 = DW'(max_disp_r - 7'd1);
    end
  end

  // configuration port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_disp_r <= RST_MAX_DISP;
      radius_r   <= RST_RADIUS;
      width_r    <= RST_WIDTH;
      height_r   <= RST_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_DISP: max_disp_r <= cfg_data[6:0];
        REG_RADIUS:   radius_r   <= cfg_data[2:0];
        REG_WIDTH:    width_r    <= cfg_data;
        REG_HEIGHT:   height_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // pixel images, one ram each
  ssdbm_ram #(.WIDTH(PIX_W), .DEPTH(1 << AB)) u_left_ram (
    .clk   (clk),
    .we    (store_go),
    .waddr (waddr),
    .wdata (left_pixel),
    .raddr (laddr),
    .rdata (lpix)
  );

  ssdbm_ram #(.WIDTH(PIX_W), .DEPTH(1 << AB)) u_right_ram (
    .clk   (clk),
    .we    (store_go),
    .waddr (waddr),
    .wdata (right_pixel),
    .raddr (raddr),
    .rdata (rpix)
  );

  ssdbm_seq #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .MAX_DISP_LIMIT (MAX_DISP_LIMIT)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (query_go),
    .col    (col),
    .row    (row),
    .radius (radius_r),
    .w1     (w1),
    .h1     (h1),
    .nd1    (nd1),
    .empty  (seq_empty),
    .run    (seq_run),
    .tag    (seq_tag),
    .d      (seq_d),
    .laddr  (laddr),
    .raddr  (raddr)
  );

  // registered tag lines up with the registered ram read data
  ssdbm_acc #(.MAX_DISP_LIMIT(MAX_DISP_LIMIT)) u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_in    (seq_tag),
    .d_in      (seq_d),
    .lpix      (lpix),
    .rpix      (rpix),
    .done      (acc_done),
    .busy      (acc_busy),
    .best_cost (best_cost),
    .best_d    (best_d)
  );

  assign out_free = !out_tvalid_r || out_tready;

  // query control and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      empty_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // a new result replaces the one taken in the same cycle
      if (state_r == ST_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (query_go) begin
            empty_r <= seq_empty;
            // window outside the image needs no reads
            state_r <= seq_empty ? ST_DONE : ST_RUN;
          end
        end
        ST_RUN: begin
          if (acc_done) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      if (empty_r) begin
        out_tdata_r <= '0;
      end else begin
        out_tdata_r <= {{OUT_PAD{1'b0}}, best_cost, OUT_DISP_W'(best_d)};
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // nothing in flight while new items are taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!seq_run && !acc_busy))
    else $error("pipeline active while idle");

  // reads are issued only during a query
  a_reads_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    seq_tag.vld |-> (state_r == ST_RUN))
    else $error("ram read outside a query");

  // the last sum of a query arrives only while it runs
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    acc_done |-> (state_r == ST_RUN))
    else $error("query finished outside run state");

  // sequencer stops by the time the final sum leaves the pipeline
  a_seq_stops: assert property (@(posedge clk) disable iff (!rst_n)
    acc_done |-> !seq_run)
    else $error("sequencer still running at query end");

endmodule

>>> test/tb_top.sv
// testbench for the ssd block matching disparity unit, self-checking against its own predictor
module tb_top
  import ssdbm_pkg::*;
();

  // geometry of the pixel stores, matched to the unit's parameters
  localparam int PIX_COLS       = 256;
  localparam int PIX_ROWS       = 256;
  localparam int DISP_LIMIT     = 64;
  localparam int CLK_PERIOD     = 4;
  // quiet cycles before a register write and at the end of the run
  localparam int SETTLE_CYCLES  = 16;
  // long receiver hold-off that lets the unit fill up and stall its input
  localparam int RX_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS    = 12;
  localparam int TIMEOUT_CYCLES = 2_500_000;

  // one result item as the unit returns it
  typedef struct packed {
    logic [OUT_DISP_W-1:0] disparity;
    logic [COST_W-1:0]     best_cost;
  } match_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state: both pixel images, which entries hold a written pixel,
  // and a copy of the four registers
  bit   [PIX_W-1:0] left_pix  [PIX_COLS*PIX_ROWS];
  bit   [PIX_W-1:0] right_pix [PIX_COLS*PIX_ROWS];
  bit               written   [PIX_COLS*PIX_ROWS];
  logic [6:0]       nd_reg;
  logic [2:0]       radius_reg;
  logic [8:0]       width_reg;
  logic [8:0]       height_reg;

  // results still owed by the unit, oldest first
  match_t pending_matches [$];

  int          error_count   = 0;
  int unsigned items_sent    = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          rx_hold_req   = 0;
  int          rx_hold_left  = 0;

  ssd_block_match_disparity_unit #(
    .MAX_WIDTH      (PIX_COLS),
    .MAX_HEIGHT     (PIX_ROWS),
    .MAX_DISP_LIMIT (DISP_LIMIT)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // col, row, left_pixel, right_pixel
    .in_tuser   (in_tuser),   // op
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // disparity, best_cost, zero pad
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD/2);
    clk = 1'b1;
    #(CLK_PERIOD/2);
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // zero counts as one, anything above the hardware limit saturates
  function automatic int limit_range(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // sum of squared differences over the clipped window at one disparity;
  // the left sample column is clamped to the last image column
  function automatic int unsigned window_ssd(input int col, input int row, input int d,
                                             input int w, input int h, input int r);
    int          i0, i1, j0, j1, ii, jj, sc, diff;
    int unsigned sum;
    i0  = (row - r < 0) ? 0 : row - r;
    i1  = (row + r > h - 1) ? h - 1 : row + r;
    j0  = (col - r < 0) ? 0 : col - r;
    j1  = (col + r > w - 1) ? w - 1 : col + r;
    sum = 0;
    for (ii = i0; ii <= i1; ii++) begin
      for (jj = j0; jj <= j1; jj++) begin
        sc   = (jj + d > w - 1) ? w - 1 : jj + d;
        diff = int'(left_pix[ii*PIX_COLS + sc]) - int'(right_pix[ii*PIX_COLS + jj]);
        sum += diff * diff;
      end
    end
    return sum;
  endfunction

  // winner take all over the disparities in use, lowest disparity wins a tie
  function automatic match_t predict_match(input int col, input int row);
    int          w, h, nd, r, d, best_d;
    int unsigned best, cost;
    match_t      m;
    w      = limit_range(int'(width_reg), PIX_COLS);
    h      = limit_range(int'(height_reg), PIX_ROWS);
    nd     = limit_range(int'(nd_reg), DISP_LIMIT);
    r      = int'(radius_reg);
    best   = window_ssd(col, row, 0, w, h, r);
    best_d = 0;
    for (d = 1; d < nd; d++) begin
      cost = window_ssd(col, row, d, w, h, r);
      if (cost < best) begin
        best   = cost;
        best_d = d;
      end
    end
    m.disparity = best_d[OUT_DISP_W-1:0];
    m.best_cost = best[COST_W-1:0];
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offers one item, with a random lead-in gap, and updates the predictor
  // at the edge where the item is taken
  task automatic send_item(input logic op, input logic [7:0] col, input logic [7:0] row,
                           input logic [7:0] lp, input logic [7:0] rp);
    int unsigned addr;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {rp, lp, row, col};
    do @(posedge clk); while (!in_tready);
    addr = int'(row) * PIX_COLS + int'(col);
    if (op == OP_STORE) begin
      left_pix[addr]  = lp;
      right_pix[addr] = rp;
      written[addr]   = 1'b1;
    end else begin
      pending_matches.push_back(predict_match(int'(col), int'(row)));
    end
    items_sent++;
  endtask

  // stores random pixels at every entry a query at (col,row) would read
  // that holds no pixel yet, so the unit never reads an unwritten entry
  task automatic fill_window(input int col, input int row);
    int w, h, nd, r, i0, i1, j0, j1, jlast, ii, jj;
    w     = limit_range(int'(width_reg), PIX_COLS);
    h     = limit_range(int'(height_reg), PIX_ROWS);
    nd    = limit_range(int'(nd_reg), DISP_LIMIT);
    r     = int'(radius_reg);
    i0    = (row - r < 0) ? 0 : row - r;
    i1    = (row + r > h - 1) ? h - 1 : row + r;
    j0    = (col - r < 0) ? 0 : col - r;
    j1    = (col + r > w - 1) ? w - 1 : col + r;
    // left samples reach up to nd-1 columns further right, clamped
    jlast = (j1 + nd - 1 > w - 1) ? w - 1 : j1 + nd - 1;
    for (ii = i0; ii <= i1; ii++) begin
      for (jj = j0; jj <= jlast; jj++) begin
        if (!written[ii*PIX_COLS + jj]) begin
          send_item(OP_STORE, jj[7:0], ii[7:0], 8'($urandom_range(255)),
                    8'($urandom_range(255)));
        end
      end
    end
  endtask

  task automatic query_pixel(input int col, input int row);
    fill_window(col, row);
    // pixel fields are don't-care on a query, so they carry random bits
    send_item(OP_QUERY, col[7:0], row[7:0], 8'($urandom_range(255)),
              8'($urandom_range(255)));
  endtask

  // drops valid and waits until every owed result has come back
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_matches.size() != 0);
  endtask

  // unit idle: nothing owed and any store still in flight finished
  task automatic settle();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    // registers keep only their own width; other indexes are dropped
    case (idx)
      REG_MAX_DISP: nd_reg     = val[6:0];
      REG_RADIUS:   radius_reg = val[2:0];
      REG_WIDTH:    width_reg  = val[8:0];
      REG_HEIGHT:   height_reg = val[8:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: checks every taken result and drives out_tready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    match_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.disparity = out_tdata[OUT_DISP_W-1:0];
      got.best_cost = out_tdata[OUT_DISP_W +: COST_W];
      if (pending_matches.size() == 0) begin
        $display("%0t: result with none owed: disparity %0d cost %0d", $time,
                 got.disparity, got.best_cost);
        error_count++;
      end else begin
        want = pending_matches.pop_front();
        if (got.disparity !== want.disparity) begin
          $display("%0t: disparity mismatch: expected %0d got %0d", $time,
                   want.disparity, got.disparity);
          error_count++;
        end
        if (got.best_cost !== want.best_cost) begin
          $display("%0t: best_cost mismatch: expected %0d got %0d", $time,
                   want.best_cost, got.best_cost);
          error_count++;
        end
      end
    end
    // a hold-off request is counted down here, one cycle per edge
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset register values: nd 16, radius 2, full 256 by 256 image;
  // the corner query keeps the window and the shifted columns small
  task automatic test_reset_config();
    query_pixel(255, 255);
  endtask

  // zero sizes and zero count act as one, a count past the limit saturates,
  // and a window that misses the image returns disparity 0, cost 0
  task automatic test_register_extremes();
    settle();
    write_reg(REG_WIDTH, 9'd0);
    write_reg(REG_HEIGHT, 9'd0);
    write_reg(REG_RADIUS, 9'd7);
    write_reg(REG_MAX_DISP, 9'd127);
    send_item(OP_STORE, 8'd0, 8'd0, 8'd255, 8'd0);
    query_pixel(0, 0);
    query_pixel(7, 7);
    query_pixel(255, 255);
    settle();
    write_reg(REG_MAX_DISP, 9'd0);
    query_pixel(0, 0);
  endtask

  // a store outside the image in use is kept and read once the image grows;
  // oversized width and height saturate to the store size
  task automatic test_store_outside_image();
    send_item(OP_STORE, 8'd255, 8'd100, 8'd0, 8'd255);
    settle();
    write_reg(REG_WIDTH, 9'd511);
    write_reg(REG_HEIGHT, 9'd257);
    write_reg(REG_RADIUS, 9'd0);
    write_reg(REG_MAX_DISP, 9'd64);
    query_pixel(255, 100);
  endtask

  // writes to unknown indexes change nothing; high data bits are dropped
  task automatic test_unknown_register();
    settle();
    write_reg(8'd4, 9'h1FF);
    write_reg(8'hFF, 9'h000);
    query_pixel(255, 100);
    settle();
    write_reg(REG_RADIUS, 9'h1F9);
    write_reg(REG_MAX_DISP, 9'h181);
    query_pixel(255, 100);
    query_pixel(255, 255);
  endtask

  // two-column image where the shifted match is better, plus a clamped shift
  task automatic test_shift_and_tie();
    settle();
    write_reg(REG_WIDTH, 9'd2);
    write_reg(REG_HEIGHT, 9'd1);
    write_reg(REG_RADIUS, 9'd1);
    write_reg(REG_MAX_DISP, 9'd2);
    send_item(OP_STORE, 8'd0, 8'd0, 8'd10, 8'd20);
    send_item(OP_STORE, 8'd1, 8'd0, 8'd20, 8'd30);
    query_pixel(0, 0);
    query_pixel(1, 0);
  endtask

  // receiver holds off while queries keep coming, so the output register
  // and the engine both fill and input stalls; then the sender waits for
  // every result before going on
  task automatic test_backpressure();
    int cols [8];
    int rows [8];
    int k;
    settle();
    write_reg(REG_WIDTH, 9'd6);
    write_reg(REG_HEIGHT, 9'd6);
    write_reg(REG_RADIUS, 9'd1);
    write_reg(REG_MAX_DISP, 9'd8);
    send_idle_pct = 0;
    stall_pct     = 0;
    for (k = 0; k < 8; k++) begin
      cols[k] = $urandom_range(5);
      rows[k] = $urandom_range(5);
      fill_window(cols[k], rows[k]);
    end
    rx_hold_req = RX_HOLD_CYCLES;
    for (k = 0; k < 8; k++) begin
      send_item(OP_QUERY, cols[k][7:0], rows[k][7:0], 8'($urandom_range(255)),
                8'($urandom_range(255)));
    end
    wait_drain();
    for (k = 0; k < 4; k++) begin
      query_pixel($urandom_range(5), $urandom_range(5));
    end
  endtask

  // one register setting per phase, random stores and queries on a small image
  task automatic run_random_phase(input int idle_pct, input int stall);
    int          wc, hc, col, row;
    int unsigned start;
    settle();
    if ($urandom_range(99) < 80) begin
      write_reg(REG_MAX_DISP, 9'($urandom_range(12)));
    end else begin
      write_reg(REG_MAX_DISP, 9'($urandom_range(13, 127)));
    end
    write_reg(REG_RADIUS, 9'($urandom_range(7)));
    write_reg(REG_WIDTH, 9'($urandom_range(9)));
    write_reg(REG_HEIGHT, 9'($urandom_range(9)));
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    start         = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      wc = limit_range(int'(width_reg), PIX_COLS);
      hc = limit_range(int'(height_reg), PIX_ROWS);
      if ($urandom_range(99) < 55) begin
        // mostly inside the image, some anywhere (often an empty window)
        if ($urandom_range(99) < 75) begin
          col = $urandom_range(wc - 1);
          row = $urandom_range(hc - 1);
        end else begin
          col = $urandom_range(255);
          row = $urandom_range(255);
        end
        query_pixel(col, row);
      end else begin
        if ($urandom_range(1) == 0) begin
          col = $urandom_range(wc - 1);
          row = $urandom_range(hc - 1);
        end else begin
          col = $urandom_range(255);
          row = $urandom_range(255);
        end
        send_item(OP_STORE, col[7:0], row[7:0], 8'($urandom_range(255)),
                  8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0);
    run_random_phase(57, 0);
    run_random_phase(0, 57);
    run_random_phase(37, 37);
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  // ---------------------------------------------------------------------------
  // run sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_STORE;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    nd_reg     = RST_MAX_DISP;
    radius_reg = RST_RADIUS;
    width_reg  = RST_WIDTH;
    height_reg = RST_HEIGHT;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_config();
    test_register_extremes();
    test_store_outside_image();
    test_unknown_register();
    test_shift_and_tie();
    test_backpressure();
    test_random_traffic();

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("TB_ERROR");
    $finish;
  end

endmodule
